[rtl/bss_pkg.sv]
// Shared types, constants and codes for the slope stepper.
package bss_pkg;

  localparam int DELTA_BITS = 12;
  localparam int VALUE_BITS = 16;

  localparam int ERR_BITS  = DELTA_BITS + 2;
  localparam int STEP_BITS = DELTA_BITS + 1;
  localparam int CMP_BITS  = DELTA_BITS + 4;
  localparam int EXT_BITS  = (VALUE_BITS > STEP_BITS) ? VALUE_BITS : STEP_BITS;
  localparam int CNT_BITS  = $clog2(DELTA_BITS);

  typedef enum logic [1:0] {
    REQ_LOAD = 2'd0,
    REQ_FWD  = 2'd1,
    REQ_BWD  = 2'd2,
    REQ_NOP  = 2'd3
  } req_code_t;

  typedef enum logic {
    STATUS_OK     = 1'b0,
    STATUS_REJECT = 1'b1
  } status_code_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic [1:0]                    req_type;
    logic signed [DELTA_BITS-1:0]  major_delta;
    logic signed [DELTA_BITS-1:0]  minor_delta;
    logic signed [VALUE_BITS-1:0]  start_value;
  } req_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0]  value_before;
    logic signed [VALUE_BITS-1:0]  value_after;
    logic                          status;
  } result_t;

  // Controller to datapath.
  typedef struct packed {
    logic exec;         // perform a request that needs no divider now
    logic div_start;    // latch a load and seed the divider
    logic div_step;     // advance the divider by one quotient bit
    logic load_commit;  // write derived line state and emit the result
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic out_free;     // result register can take a new value this cycle
    logic load_div;     // pending request is a load that needs the divider
  } stat_t;

endpackage

[rtl/bss_div.sv]
// Restoring unsigned divider, one quotient bit per cycle while step is high.
module bss_div (
  input  logic                            clk,
  input  logic                            start,
  input  logic                            step,
  input  logic [bss_pkg::DELTA_BITS-1:0]  dividend,
  input  logic [bss_pkg::DELTA_BITS-1:0]  divisor,
  output logic [bss_pkg::DELTA_BITS-1:0]  quotient,
  output logic [bss_pkg::DELTA_BITS-1:0]  remainder
);
  import bss_pkg::*;

  logic [DELTA_BITS-1:0] quo;
  logic [DELTA_BITS-1:0] rem;
  logic [DELTA_BITS-1:0] dvs;
  logic [DELTA_BITS:0]   trial;
  logic                  fits;

  assign trial = {rem, quo[DELTA_BITS-1]};
  assign fits  = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (step) begin
      quo <= {quo[DELTA_BITS-2:0], fits};
      rem <= fits ? DELTA_BITS'(trial - {1'b0, dvs}) : DELTA_BITS'(trial);
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

[rtl/bss_dp.sv]
// Datapath: line state, step arithmetic, load setup and result register.
module bss_dp (
  input  logic             clk,
  input  logic             rst,
  input  bss_pkg::req_t    req,
  input  bss_pkg::cmd_t    cmd,
  output bss_pkg::stat_t   stat,
  output logic             result_valid,
  input  logic             result_ready,
  output bss_pkg::result_t result
);
  import bss_pkg::*;

  // Line state.
  logic signed [VALUE_BITS-1:0] cur_value, cur_value_next;
  logic signed [ERR_BITS-1:0]   err_term, err_term_next;
  logic signed [STEP_BITS-1:0]  small_step;
  logic signed [STEP_BITS-1:0]  large_step;
  logic signed [STEP_BITS-1:0]  err_add_small;
  logic signed [ERR_BITS-1:0]   err_add_large;

  // Load held while the divider runs.
  logic signed [VALUE_BITS-1:0] ld_start;
  logic                         ld_sign;
  logic [DELTA_BITS-1:0]        ld_amaj;

  logic [DELTA_BITS-1:0] amaj, amin;
  logic                  maj_pos, min_pos, maj_zero;
  logic [DELTA_BITS-1:0] quotient, remainder;

  logic signed [STEP_BITS-1:0] ss_new, ls_new, eas_new;
  logic signed [ERR_BITS-1:0]  eal_new, et_new;

  logic signed [EXT_BITS-1:0]  ls_ext, ss_ext;
  logic signed [ERR_BITS-1:0]  eas_ext;
  logic signed [CMP_BITS-1:0]  back_diff;
  logic                        fwd_large, bwd_large;
  logic                        out_status;

  assign maj_zero = (req.major_delta == '0);
  assign maj_pos  = !req.major_delta[DELTA_BITS-1] && !maj_zero;
  assign min_pos  = !req.minor_delta[DELTA_BITS-1] && (req.minor_delta != '0);
  assign amaj     = req.major_delta[DELTA_BITS-1] ? DELTA_BITS'(-req.major_delta)
                                                  : req.major_delta;
  assign amin     = req.minor_delta[DELTA_BITS-1] ? DELTA_BITS'(-req.minor_delta)
                                                  : req.minor_delta;

  assign stat.load_div = (req.req_type == REQ_LOAD) && !maj_zero;
  assign stat.out_free = !result_valid || result_ready;

  bss_div u_div (
    .clk       (clk),
    .start     (cmd.div_start),
    .step      (cmd.div_step),
    .dividend  (amin),
    .divisor   (amaj),
    .quotient  (quotient),
    .remainder (remainder)
  );

  // Derived line parameters from quotient and remainder.
  always_comb begin
    ss_new  = ld_sign ? STEP_BITS'(-$signed({1'b0, quotient}))
                      : $signed({1'b0, quotient});
    ls_new  = ld_sign ? STEP_BITS'(ss_new - 1'b1) : STEP_BITS'(ss_new + 1'b1);
    eas_new = $signed({remainder, 1'b0});
    eal_new = ERR_BITS'($signed({1'b0, remainder, 1'b0}) - $signed({1'b0, ld_amaj, 1'b0}));
    et_new  = ERR_BITS'($signed({1'b0, remainder, 1'b0}) - $signed({2'b00, ld_amaj}));
  end

  // Step arithmetic: a backward step undoes the matching forward step.
  always_comb begin
    ls_ext    = EXT_BITS'(large_step);
    ss_ext    = EXT_BITS'(small_step);
    eas_ext   = ERR_BITS'(err_add_small);
    back_diff = CMP_BITS'(err_term) - CMP_BITS'(err_add_large) - CMP_BITS'(err_add_small);
    fwd_large = (err_term > 0);
    bwd_large = (back_diff <= 0);

    cur_value_next = cur_value;
    err_term_next  = err_term;
    out_status     = STATUS_OK;
    case (req.req_type)
      REQ_LOAD: out_status = STATUS_REJECT;
      REQ_FWD: begin
        if (fwd_large) begin
          err_term_next  = ERR_BITS'(err_term + err_add_large);
          cur_value_next = VALUE_BITS'(cur_value + VALUE_BITS'(ls_ext));
        end else begin
          err_term_next  = ERR_BITS'(err_term + eas_ext);
          cur_value_next = VALUE_BITS'(cur_value + VALUE_BITS'(ss_ext));
        end
      end
      REQ_BWD: begin
        if (bwd_large) begin
          err_term_next  = ERR_BITS'(err_term - err_add_large);
          cur_value_next = VALUE_BITS'(cur_value - VALUE_BITS'(ls_ext));
        end else begin
          err_term_next  = ERR_BITS'(err_term - eas_ext);
          cur_value_next = VALUE_BITS'(cur_value - VALUE_BITS'(ss_ext));
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_value     <= '0;
      err_term      <= '0;
      small_step    <= '0;
      large_step    <= '0;
      err_add_small <= '0;
      err_add_large <= '0;
    end else if (cmd.exec) begin
      cur_value <= cur_value_next;
      err_term  <= err_term_next;
    end else if (cmd.load_commit) begin
      cur_value     <= ld_start;
      err_term      <= et_new;
      small_step    <= ss_new;
      large_step    <= ls_new;
      err_add_small <= eas_new;
      err_add_large <= eal_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      ld_start <= req.start_value;
      ld_sign  <= (maj_pos != min_pos);
      ld_amaj  <= amaj;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.exec || cmd.load_commit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      result.value_before <= cur_value;
      result.value_after  <= cur_value_next;
      result.status       <= out_status;
    end else if (cmd.load_commit) begin
      result.value_before <= cur_value;
      result.value_after  <= ld_start;
      result.status       <= STATUS_OK;
    end
  end

endmodule

[rtl/bss_ctrl.sv]
// Controller: request acceptance and divider sequencing.
module bss_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  bss_pkg::stat_t  stat,
  output bss_pkg::cmd_t   cmd
);
  import bss_pkg::*;

  state_t               state, state_next;
  logic [CNT_BITS-1:0]  cnt, cnt_next;
  logic                 last_bit;

  assign last_bit = (cnt == CNT_BITS'(DELTA_BITS - 1));

  // Next state.
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    unique case (state)
      ST_IDLE: begin
        if (req_valid && stat.out_free && stat.load_div) begin
          state_next = ST_DIV;
          cnt_next   = '0;
        end
      end
      ST_DIV: begin
        cnt_next = CNT_BITS'(cnt + 1'b1);
        if (last_bit) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd       = '0;
    req_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req_ready     = stat.out_free;
        cmd.exec      = req_valid && stat.out_free && !stat.load_div;
        cmd.div_start = req_valid && stat.out_free && stat.load_div;
      end
      ST_DIV:  cmd.div_step    = 1'b1;
      ST_FIN:  cmd.load_commit = stat.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule

[rtl/bresenham_slope_stepper_top.sv]
// Top level of the run-slice line stepper: controller plus datapath.
//
// Interpolates a value along a line whose slope has a whole part: each
// request either loads a new line (major delta, minor delta, start value)
// or steps the value one position forward or backward along the major axis,
// and every request returns exactly one result with the value before and
// after it and a status bit. Forward and backward steps, the unused request
// code and a load with a zero major delta (rejected, state kept, status set)
// are done directly without the divider, so they can be issued back to back
// as long as the result side keeps taking results. A new request is taken
// only in a cycle where the result register is empty or its result is being
// taken, so a result left waiting stalls the request side. A valid load is
// captured first, then runs through the bit-serial restoring divider that
// forms |minor| / |major| one quotient bit per cycle, then writes the step
// sizes, error increments and start value; that last write waits for the
// result register like any other result. All values wrap at their widths.
module bresenham_slope_stepper_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  bss_pkg::req_t     req,
  output logic              result_valid,
  input  logic              result_ready,
  output bss_pkg::result_t  result
);
  import bss_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Sequence the request: work done directly, or the divider loop for a load.
  bss_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Hold the line state, do the arithmetic, drive the result register.
  bss_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .req          (req),
    .cmd          (cmd),
    .stat         (stat),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
